FILE: rtl/core/tsp_pkg.sv
// Shared constants and codes of the square tile partitioner.
`default_nettype none
package tsp_pkg;
	localparam int MAX_NODES  = 1024;
	localparam int MAX_EDGES  = 4096;
	localparam int MAX_TSIDE  = 16;
	localparam int NODE_W     = 10;
	localparam int EDGE_AW    = 12;
	localparam int TIDX_W     = 4;
	localparam int CNT_W      = 13;

	typedef enum logic [2:0] {
		REQ_LOAD  = 3'd0,
		REQ_BUILD = 3'd1,
		REQ_RIDX  = 3'd2,
		REQ_RNBR  = 3'd3,
		REQ_CLEAR = 3'd4
	} req_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_FULL   = 3'd1,
		ST_RANGE  = 3'd2,
		ST_UNBUILT = 3'd3,
		ST_TILES  = 3'd4
	} status_t;

	localparam logic REG_TSIZE  = 1'b0;
	localparam logic REG_NNODES = 1'b1;
endpackage
`default_nettype wire

FILE: rtl/core/tsp_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
`default_nettype none
module tsp_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: rtl/core/csr_square_tile_partitioner.sv
// Square tile partitioner: edges of an N x N graph are loaded one per transfer,
// a build request splits the adjacency into square tiles of the configured side, each with a
// local row index and a neighbour list, and read requests return one index entry or one
// neighbour. One request is in flight at a time. Load, clear and index reads are answered
// from the execute state; a neighbour read goes on to a second read state, as its second
// memory read depends on the tile base read first. A build runs a sequencer over the
// memories: settings check, node-to-tile map sweep, edge range check, count clear,
// counting, prefix sums over the rows of each tile and scatter. Input is stalled
// throughout. Results sit in an output register; the next request is taken once it is
// transferred. Register writes are taken in any cycle.
`default_nettype none
module csr_square_tile_partitioner (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [10:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  req_type,
	input  wire logic [9:0]  row_node,
	input  wire logic [9:0]  col_node,
	input  wire logic [3:0]  tile_row,
	input  wire logic [3:0]  tile_col,
	input  wire logic [10:0] local_row,
	input  wire logic [11:0] position,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [12:0]      value,
	output logic [4:0]       tiles_per_side
);
	typedef enum logic [4:0] {
		S_IDLE, S_EXEC, S_RD2, S_MAP, S_ECHK_A, S_ECHK_B, S_CLR,
		S_CNT_A, S_CNT_B, S_CNT_C, S_CNT_D, S_PFX_A, S_PFX_B,
		S_SCT_A, S_SCT_B, S_SCT_C, S_SCT_D
	} state_t;

	state_t       state_q;
	logic         out_valid_q;
	logic [2:0]   status_q;
	logic [12:0]  value_q;
	logic [4:0]   tps_out_q;

	// Settings and persistent control
	logic [10:0]  ts_q, nn_q;
	logic [12:0]  total_q;
	logic         built_q;
	logic [4:0]   tps_q;

	// Captured request
	logic [2:0]   req_q;
	logic [9:0]   row_q, col_q;
	logic [3:0]   tr_in_q, tc_in_q;
	logic [10:0]  lr_q;
	logic [11:0]  pos_q;
	logic [14:0]  prod_q;

	// Build sequencer
	logic [10:0]  n_q;
	logic [9:0]   loc_q;
	logic [4:0]   ntile_q;
	logic [12:0]  e_q;
	logic [10:0]  g_q;
	logic [3:0]   c_q;
	logic [3:0]   tr_q;
	logic [10:0]  rs_q;
	logic [12:0]  base_q, acc_q;
	logic [9:0]   erow_q;
	logic [9:0]   lloc_q;
	logic [13:0]  k_q;

	// Memory ports
	logic         edge_we;
	logic [11:0]  edge_waddr, edge_raddr;
	logic [19:0]  edge_wdata, edge_rdata;
	logic         node_we;
	logic [9:0]   node_waddr, node_raddr;
	logic [13:0]  node_wdata, node_rdata;
	logic         cnt_we;
	logic [13:0]  cnt_waddr, cnt_raddr;
	logic [12:0]  cnt_wdata, cnt_rdata;
	logic         ofs_we;
	logic [13:0]  ofs_waddr, ofs_raddr;
	logic [12:0]  ofs_wdata, ofs_rdata;
	logic         tile_we;
	logic [7:0]   tile_waddr, tile_raddr;
	logic [25:0]  tile_wdata, tile_rdata;
	logic         nbr_we;
	logic [11:0]  nbr_waddr, nbr_raddr;
	logic [9:0]   nbr_wdata, nbr_rdata;

	// Derived values
	logic [14:0]  prod_in, g_in;
	logic         load_ok;
	logic [4:0]   tps_vis;
	logic [11:0]  rest;
	logic [10:0]  nrows;
	logic [12:0]  t_base, t_count;
	logic [13:0]  nbr_p;
	logic         nbr_bad;
	logic [11:0]  rs_next;
	logic [10:0]  rend;
	logic [9:0]   loc_next;
	logic [4:0]   ntile_dec;
	logic [3:0]   map_tile;
	logic         map_fail;
	logic         cfg_bad;

	assign in_ready       = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign value          = value_q;
	assign tiles_per_side = tps_out_q;

	assign prod_in  = 15'(tile_row) * 15'(ts_q);
	assign g_in     = prod_in + 15'(local_row);
	assign load_ok  = (total_q < 13'(tsp_pkg::MAX_EDGES)) && (11'(row_q) < nn_q)
		&& (11'(col_q) < nn_q);
	assign tps_vis  = built_q ? tps_q : 5'd0;
	assign rest     = 12'(nn_q) - 12'(prod_q[10:0]);
	assign nrows    = (12'(ts_q) < rest) ? ts_q : rest[10:0];
	assign t_base   = tile_rdata[25:13];
	assign t_count  = tile_rdata[12:0];
	assign nbr_p    = 14'(t_base) + 14'(pos_q);
	assign nbr_bad  = (13'(pos_q) >= t_count) || (nbr_p[13:12] != 2'd0);
	assign rs_next  = 12'(rs_q) + 12'(ts_q);
	assign rend     = (rs_next < 12'(nn_q)) ? rs_next[10:0] : nn_q;
	assign loc_next = (11'(loc_q) + 11'd1 == ts_q) ? 10'd0 : loc_q + 10'd1;
	assign ntile_dec = ntile_q - 5'd1;
	assign map_tile = (loc_q == 10'd0) ? ntile_q[3:0] : ntile_dec[3:0];
	assign map_fail = (loc_q == 10'd0) && (ntile_q == 5'(tsp_pkg::MAX_TSIDE));
	assign cfg_bad  = (ts_q == 11'd0) || (nn_q == 11'd0)
		|| (nn_q > 11'(tsp_pkg::MAX_NODES));

	// Memory address and write control, by sequencer state
	always_comb begin
		edge_we    = 1'b0;
		edge_waddr = total_q[11:0];
		edge_wdata = {row_q, col_q};
		edge_raddr = e_q[11:0];
		node_we    = 1'b0;
		node_waddr = n_q[9:0];
		node_wdata = {map_tile, loc_q};
		node_raddr = edge_rdata[9:0];
		cnt_we     = 1'b0;
		cnt_waddr  = k_q;
		cnt_wdata  = cnt_rdata + 13'd1;
		cnt_raddr  = {g_q[9:0], c_q};
		ofs_we     = 1'b0;
		ofs_waddr  = {g_q[9:0], c_q};
		ofs_wdata  = acc_q;
		ofs_raddr  = {g_in[9:0], tile_col};
		tile_we    = 1'b0;
		tile_waddr = {tr_q, c_q};
		tile_wdata = {base_q, acc_q};
		tile_raddr = {tile_row, tile_col};
		nbr_we     = 1'b0;
		nbr_waddr  = cnt_rdata[11:0];
		nbr_wdata  = lloc_q;
		nbr_raddr  = nbr_p[11:0];
		case (state_q)
			S_EXEC: begin
				edge_we = (req_q == tsp_pkg::REQ_LOAD) && load_ok;
			end
			S_MAP: begin
				node_we = !map_fail;
			end
			S_CLR: begin
				cnt_we    = 1'b1;
				cnt_waddr = {g_q[9:0], c_q};
				cnt_wdata = '0;
			end
			S_CNT_C, S_SCT_C: begin
				cnt_raddr = {erow_q, node_rdata[13:10]};
			end
			S_CNT_D: begin
				cnt_we = 1'b1;
			end
			S_PFX_B: begin
				cnt_we    = 1'b1;
				cnt_waddr = {g_q[9:0], c_q};
				cnt_wdata = base_q + acc_q;
				ofs_we    = 1'b1;
			end
			S_PFX_A: begin
				tile_we = (g_q >= rend);
			end
			S_SCT_D: begin
				cnt_we = 1'b1;
				nbr_we = !cnt_rdata[12];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			ts_q        <= 11'd64;
			nn_q        <= 11'd1024;
			total_q     <= '0;
			built_q     <= 1'b0;
			tps_q       <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				if (cfg_index == tsp_pkg::REG_TSIZE) begin
					ts_q <= cfg_wdata;
				end else begin
					nn_q <= cfg_wdata;
				end
				built_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						req_q   <= req_type;
						row_q   <= row_node;
						col_q   <= col_node;
						tr_in_q <= tile_row;
						tc_in_q <= tile_col;
						lr_q    <= local_row;
						pos_q   <= position;
						prod_q  <= prod_in;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (req_q)
						tsp_pkg::REQ_LOAD: begin
							state_q     <= S_IDLE;
							out_valid_q <= 1'b1;
							if (total_q >= 13'(tsp_pkg::MAX_EDGES)) begin
								status_q  <= tsp_pkg::ST_FULL;
								value_q   <= '0;
								tps_out_q <= tps_vis;
							end else if (!load_ok) begin
								status_q  <= tsp_pkg::ST_RANGE;
								value_q   <= '0;
								tps_out_q <= tps_vis;
							end else begin
								total_q   <= total_q + 13'd1;
								built_q   <= 1'b0;
								status_q  <= tsp_pkg::ST_OK;
								value_q   <= total_q + 13'd1;
								tps_out_q <= '0;
							end
						end
						tsp_pkg::REQ_BUILD: begin
							built_q <= 1'b0;
							if (cfg_bad) begin
								state_q     <= S_IDLE;
								out_valid_q <= 1'b1;
								status_q    <= tsp_pkg::ST_RANGE;
								value_q     <= '0;
								tps_out_q   <= '0;
							end else begin
								n_q     <= '0;
								loc_q   <= '0;
								ntile_q <= '0;
								state_q <= S_MAP;
							end
						end
						tsp_pkg::REQ_RIDX, tsp_pkg::REQ_RNBR: begin
							if (!built_q) begin
								state_q     <= S_IDLE;
								out_valid_q <= 1'b1;
								status_q    <= tsp_pkg::ST_UNBUILT;
								value_q     <= '0;
								tps_out_q   <= '0;
							end else if (5'(tr_in_q) >= tps_q || 5'(tc_in_q) >= tps_q) begin
								state_q     <= S_IDLE;
								out_valid_q <= 1'b1;
								status_q    <= tsp_pkg::ST_RANGE;
								value_q     <= '0;
								tps_out_q   <= tps_vis;
							end else if (req_q == tsp_pkg::REQ_RIDX) begin
								state_q     <= S_IDLE;
								out_valid_q <= 1'b1;
								tps_out_q   <= tps_vis;
								if (lr_q > nrows) begin
									status_q <= tsp_pkg::ST_RANGE;
									value_q  <= '0;
								end else if (lr_q == nrows) begin
									status_q <= tsp_pkg::ST_OK;
									value_q  <= t_count;
								end else begin
									status_q <= tsp_pkg::ST_OK;
									value_q  <= ofs_rdata;
								end
							end else if (nbr_bad) begin
								state_q     <= S_IDLE;
								out_valid_q <= 1'b1;
								status_q    <= tsp_pkg::ST_RANGE;
								value_q     <= '0;
								tps_out_q   <= tps_vis;
							end else begin
								state_q <= S_RD2;
							end
						end
						tsp_pkg::REQ_CLEAR: begin
							total_q     <= '0;
							built_q     <= 1'b0;
							state_q     <= S_IDLE;
							out_valid_q <= 1'b1;
							status_q    <= tsp_pkg::ST_OK;
							value_q     <= '0;
							tps_out_q   <= '0;
						end
						default: begin
							state_q     <= S_IDLE;
							out_valid_q <= 1'b1;
							status_q    <= tsp_pkg::ST_RANGE;
							value_q     <= '0;
							tps_out_q   <= tps_vis;
						end
					endcase
				end
				S_RD2: begin
					state_q     <= S_IDLE;
					out_valid_q <= 1'b1;
					status_q    <= tsp_pkg::ST_OK;
					value_q     <= 13'(nbr_rdata);
					tps_out_q   <= tps_vis;
				end
				// node -> (tile, local) map, tile count falls out
				S_MAP: begin
					if (map_fail) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b1;
						status_q    <= tsp_pkg::ST_TILES;
						value_q     <= '0;
						tps_out_q   <= '0;
					end else begin
						if (loc_q == 10'd0) begin
							ntile_q <= ntile_q + 5'd1;
						end
						loc_q <= loc_next;
						n_q   <= n_q + 11'd1;
						if (n_q + 11'd1 == nn_q) begin
							tps_q   <= (loc_q == 10'd0) ? ntile_q + 5'd1 : ntile_q;
							e_q     <= '0;
							g_q     <= '0;
							c_q     <= '0;
							state_q <= (total_q == 13'd0) ? S_CLR : S_ECHK_A;
						end
					end
				end
				S_ECHK_A: begin
					state_q <= S_ECHK_B;
				end
				S_ECHK_B: begin
					if (11'(edge_rdata[19:10]) >= nn_q || 11'(edge_rdata[9:0]) >= nn_q) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b1;
						status_q    <= tsp_pkg::ST_RANGE;
						value_q     <= '0;
						tps_out_q   <= '0;
					end else if (e_q + 13'd1 == total_q) begin
						state_q <= S_CLR;
					end else begin
						e_q     <= e_q + 13'd1;
						state_q <= S_ECHK_A;
					end
				end
				S_CLR: begin
					if (5'(c_q) + 5'd1 == tps_q) begin
						c_q <= '0;
						if (g_q + 11'd1 == nn_q) begin
							e_q    <= '0;
							g_q    <= '0;
							tr_q   <= '0;
							rs_q   <= '0;
							base_q <= '0;
							acc_q  <= '0;
							state_q <= (total_q == 13'd0) ? S_PFX_A : S_CNT_A;
						end else begin
							g_q <= g_q + 11'd1;
						end
					end else begin
						c_q <= c_q + 4'd1;
					end
				end
				S_CNT_A: begin
					state_q <= S_CNT_B;
				end
				S_CNT_B: begin
					erow_q  <= edge_rdata[19:10];
					state_q <= S_CNT_C;
				end
				S_CNT_C: begin
					k_q     <= {erow_q, node_rdata[13:10]};
					state_q <= S_CNT_D;
				end
				S_CNT_D: begin
					if (e_q + 13'd1 == total_q) begin
						e_q     <= '0;
						state_q <= S_PFX_A;
					end else begin
						e_q     <= e_q + 13'd1;
						state_q <= S_CNT_A;
					end
				end
				// per tile: row offsets, then base and count
				S_PFX_A: begin
					if (g_q < rend) begin
						state_q <= S_PFX_B;
					end else begin
						base_q <= base_q + acc_q;
						acc_q  <= '0;
						if (5'(c_q) + 5'd1 == tps_q) begin
							c_q <= '0;
							if (5'(tr_q) + 5'd1 == tps_q) begin
								e_q <= '0;
								if (total_q == 13'd0) begin
									built_q     <= 1'b1;
									state_q     <= S_IDLE;
									out_valid_q <= 1'b1;
									status_q    <= tsp_pkg::ST_OK;
									value_q     <= total_q;
									tps_out_q   <= tps_q;
								end else begin
									state_q <= S_SCT_A;
								end
							end else begin
								tr_q <= tr_q + 4'd1;
								rs_q <= rs_next[10:0];
								g_q  <= rs_next[10:0];
							end
						end else begin
							c_q <= c_q + 4'd1;
							g_q <= rs_q;
						end
					end
				end
				S_PFX_B: begin
					acc_q   <= acc_q + cnt_rdata;
					g_q     <= g_q + 11'd1;
					state_q <= S_PFX_A;
				end
				S_SCT_A: begin
					state_q <= S_SCT_B;
				end
				S_SCT_B: begin
					erow_q  <= edge_rdata[19:10];
					state_q <= S_SCT_C;
				end
				S_SCT_C: begin
					k_q     <= {erow_q, node_rdata[13:10]};
					lloc_q  <= node_rdata[9:0];
					state_q <= S_SCT_D;
				end
				S_SCT_D: begin
					if (e_q + 13'd1 == total_q) begin
						built_q     <= 1'b1;
						state_q     <= S_IDLE;
						out_valid_q <= 1'b1;
						status_q    <= tsp_pkg::ST_OK;
						value_q     <= total_q;
						tps_out_q   <= tps_q;
					end else begin
						e_q     <= e_q + 13'd1;
						state_q <= S_SCT_A;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// edge store: {row, col}
	tsp_ram #(.DEPTH(tsp_pkg::MAX_EDGES), .WIDTH(2 * tsp_pkg::NODE_W)) u_edge_ram (
		.clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
		.raddr(edge_raddr), .rdata(edge_rdata)
	);

	// node map: {tile index, local number}
	tsp_ram #(.DEPTH(tsp_pkg::MAX_NODES), .WIDTH(tsp_pkg::TIDX_W + tsp_pkg::NODE_W)) u_node_ram (
		.clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
		.raddr(node_raddr), .rdata(node_rdata)
	);

	// per (row, tile column): edge count, then scatter cursor
	tsp_ram #(.DEPTH(tsp_pkg::MAX_NODES * tsp_pkg::MAX_TSIDE), .WIDTH(tsp_pkg::CNT_W)) u_cnt_ram (
		.clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
		.raddr(cnt_raddr), .rdata(cnt_rdata)
	);

	// per (row, tile column): local row offset
	tsp_ram #(.DEPTH(tsp_pkg::MAX_NODES * tsp_pkg::MAX_TSIDE), .WIDTH(tsp_pkg::CNT_W)) u_ofs_ram (
		.clk(clk), .we(ofs_we), .waddr(ofs_waddr), .wdata(ofs_wdata),
		.raddr(ofs_raddr), .rdata(ofs_rdata)
	);

	// per tile: {base, edge count}
	tsp_ram #(.DEPTH(tsp_pkg::MAX_TSIDE * tsp_pkg::MAX_TSIDE), .WIDTH(2 * tsp_pkg::CNT_W)) u_tile_ram (
		.clk(clk), .we(tile_we), .waddr(tile_waddr), .wdata(tile_wdata),
		.raddr(tile_raddr), .rdata(tile_rdata)
	);

	// tiled neighbour lists
	tsp_ram #(.DEPTH(tsp_pkg::MAX_EDGES), .WIDTH(tsp_pkg::NODE_W)) u_nbr_ram (
		.clk(clk), .we(nbr_we), .waddr(nbr_waddr), .wdata(nbr_wdata),
		.raddr(nbr_raddr), .rdata(nbr_rdata)
	);
endmodule
`default_nettype wire
